@@ hdl/periodic_min_image_distance_defines.svh @@
// Assertion macros shared by the minimum image distance modules.
`ifndef PERIODIC_MIN_IMAGE_DISTANCE_DEFINES_SVH
`define PERIODIC_MIN_IMAGE_DISTANCE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define PMID_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that a condition never holds outside reset.
`define PMID_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

@@ hdl/pmid_pkg.sv @@
// Shared types and constants of the minimum image distance block.
package pmid_pkg;

  localparam int unsigned REG_BITS = 23;
  localparam int unsigned NEED_BITS = REG_BITS + 2;
  localparam int unsigned CFG_IDX_BITS = 2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_EXTENT = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CUTOFF_RADIUS = 2'd1;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } cand_ctl_t;

endpackage

@@ hdl/pmid_seq.sv @@
// Coefficient sequencer: steps through every lattice combination of one box.
`include "periodic_min_image_distance_defines.svh"

module pmid_seq #(
  parameter int unsigned SEARCH_RANGE = 2,
  localparam int unsigned CoefBits = $clog2(SEARCH_RANGE + 1) + 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  output logic                       accept_o,
  output logic signed [CoefBits-1:0] coef_a_o,
  output logic signed [CoefBits-1:0] coef_b_o,
  output logic signed [CoefBits-1:0] coef_c_o,
  output pmid_pkg::cand_ctl_t        ctl_o
);

  localparam logic signed [CoefBits-1:0] CoefMax = CoefBits'(SEARCH_RANGE);
  localparam logic signed [CoefBits-1:0] CoefMin = -CoefMax;

  logic                       active_q, active_d;
  logic signed [CoefBits-1:0] ca_q, ca_d, cb_q, cb_d, cc_q, cc_d;
  logic                       at_last, accept;

  assign at_last  = active_q && (ca_q == CoefMax) && (cb_q == CoefMax) && (cc_q == CoefMax);
  assign busy_o   = active_q && !at_last;
  assign accept   = start_i && !busy_o;
  assign accept_o = accept;

  always_comb begin
    active_d = active_q;
    ca_d     = ca_q;
    cb_d     = cb_q;
    cc_d     = cc_q;
    if (accept) begin
      active_d = 1'b1;
      ca_d     = CoefMin;
      cb_d     = CoefMin;
      cc_d     = CoefMin;
    end else if (at_last) begin
      active_d = 1'b0;
    end else if (active_q) begin
      if (cc_q != CoefMax) begin
        cc_d = cc_q + 1'b1;
      end else begin
        cc_d = CoefMin;
        if (cb_q != CoefMax) begin
          cb_d = cb_q + 1'b1;
        end else begin
          cb_d = CoefMin;
          ca_d = ca_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      ca_q     <= '0;
      cb_q     <= '0;
      cc_q     <= '0;
    end else begin
      active_q <= active_d;
      ca_q     <= ca_d;
      cb_q     <= cb_d;
      cc_q     <= cc_d;
    end
  end

  // Drop the all-zero combination.
  always_comb begin
    ctl_o.valid = active_q && !((ca_q == '0) && (cb_q == '0) && (cc_q == '0));
    ctl_o.first = active_q && (ca_q == CoefMin) && (cb_q == CoefMin) && (cc_q == CoefMin);
    ctl_o.last  = at_last;
  end

  assign coef_a_o = ca_q;
  assign coef_b_o = cb_q;
  assign coef_c_o = cc_q;

  `PMID_ASSERT(a_first_after_accept, accept |=> (ctl_o.first && ctl_o.valid), "sequence did not restart")
  `PMID_ASSERT(a_last_once, ctl_o.last |=> !ctl_o.last, "last combination repeated")

endmodule

@@ hdl/pmid_len.sv @@
// Squared length pipeline: combine, take magnitude, square and sum per candidate.
module pmid_len #(
  parameter int unsigned COORD_BITS   = 24,
  parameter int unsigned SEARCH_RANGE = 2,
  localparam int unsigned CoefBits = $clog2(SEARCH_RANGE + 1) + 1,
  localparam int unsigned ProdBits = COORD_BITS + CoefBits,
  localparam int unsigned MagBits  = COORD_BITS - 1 + $clog2(3 * SEARCH_RANGE),
  localparam int unsigned CombBits = MagBits + 1,
  localparam int unsigned SqBits   = 2 * MagBits,
  localparam int unsigned LenBits  = 2 * MagBits + 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  logic signed [COORD_BITS-1:0] vec_i [9],
  input  logic signed [CoefBits-1:0]   coef_a_i,
  input  logic signed [CoefBits-1:0]   coef_b_i,
  input  logic signed [CoefBits-1:0]   coef_c_i,
  input  pmid_pkg::cand_ctl_t          ctl_i,
  output logic [LenBits-1:0]           len_o,
  output pmid_pkg::cand_ctl_t          ctl_o
);

  logic signed [COORD_BITS-1:0] vec_q [9];
  logic signed [ProdBits-1:0]   prod_d [9];
  logic signed [ProdBits-1:0]   prod_q [9];
  logic signed [CombBits-1:0]   comb_sum [3];
  logic [MagBits-1:0]           mag_d [3];
  logic [MagBits-1:0]           mag_q [3];
  logic [SqBits-1:0]            sq_d [3];
  logic [SqBits-1:0]            sq_q [3];
  logic [LenBits-1:0]           len_d, len_q;
  pmid_pkg::cand_ctl_t          ctl1_q, ctl2_q, ctl3_q, ctl4_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      vec_q <= vec_i;
    end
  end

  always_comb begin
    for (int ax = 0; ax < 3; ax++) begin
      prod_d[ax]     = ProdBits'(coef_a_i) * ProdBits'(vec_q[ax]);
      prod_d[3 + ax] = ProdBits'(coef_b_i) * ProdBits'(vec_q[3 + ax]);
      prod_d[6 + ax] = ProdBits'(coef_c_i) * ProdBits'(vec_q[6 + ax]);
    end
  end

  always_comb begin
    for (int ax = 0; ax < 3; ax++) begin
      comb_sum[ax] = CombBits'(prod_q[ax]) + CombBits'(prod_q[3 + ax])
                   + CombBits'(prod_q[6 + ax]);
      mag_d[ax]    = comb_sum[ax][CombBits-1] ? MagBits'(-comb_sum[ax])
                                              : MagBits'(comb_sum[ax]);
    end
  end

  always_comb begin
    for (int ax = 0; ax < 3; ax++) begin
      sq_d[ax] = SqBits'(mag_q[ax]) * SqBits'(mag_q[ax]);
    end
  end

  assign len_d = LenBits'(sq_q[0]) + LenBits'(sq_q[1]) + LenBits'(sq_q[2]);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    mag_q  <= mag_d;
    sq_q   <= sq_d;
    len_q  <= len_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
      ctl3_q <= '0;
      ctl4_q <= '0;
    end else begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
      ctl3_q <= ctl2_q;
      ctl4_q <= ctl3_q;
    end
  end

  assign len_o = len_q;
  assign ctl_o = ctl4_q;

endmodule

@@ hdl/pmid_min.sv @@
// Running minimum of the squared lengths of one box.
module pmid_min #(
  parameter int unsigned LEN_BITS = 54
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [LEN_BITS-1:0] len_i,
  input  pmid_pkg::cand_ctl_t ctl_i,
  output logic                load_o,
  output logic [LEN_BITS-1:0] min_o
);

  logic [LEN_BITS-1:0] best_q, best_d, min_q;
  logic                load_q, load_d;

  always_comb begin
    best_d = best_q;
    if (ctl_i.valid && (ctl_i.first || (len_i < best_q))) begin
      best_d = len_i;
    end
    load_d = ctl_i.valid && ctl_i.last;
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    min_q  <= best_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q <= 1'b0;
    end else begin
      load_q <= load_d;
    end
  end

  assign load_o = load_q;
  assign min_o  = min_q;

endmodule

@@ hdl/pmid_sqrt.sv @@
// Bit-serial floor square root and margin compare of the result.
`include "periodic_min_image_distance_defines.svh"

module pmid_sqrt #(
  parameter int unsigned ROOT_BITS = 27,
  localparam int unsigned RadBits = 2 * ROOT_BITS,
  localparam int unsigned CntBits = $clog2(ROOT_BITS),
  localparam int unsigned CmpBits = (ROOT_BITS > pmid_pkg::NEED_BITS) ? ROOT_BITS
                                                                     : pmid_pkg::NEED_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           load_i,
  input  logic [RadBits-1:0]             rad_i,
  input  logic [pmid_pkg::NEED_BITS-1:0] need_i,
  output logic                           done_o,
  output logic [ROOT_BITS-1:0]           root_o,
  output logic                           margin_o
);

  logic                 busy_q, busy_d;
  logic [CntBits-1:0]   cnt_q, cnt_d;
  logic [RadBits-1:0]   rad_q, rad_d;
  logic [ROOT_BITS:0]   rem_q, rem_d;
  logic [ROOT_BITS-1:0] root_q, root_d, root_step;
  logic [ROOT_BITS+2:0] rem_cat, trial, rem_step;
  logic                 fit;
  logic                 fin_q, fin_d;
  logic [ROOT_BITS-1:0] fin_root_q;
  logic                 done_q;
  logic [ROOT_BITS-1:0] dist_q;
  logic                 margin_q;

  assign rem_cat   = {rem_q, rad_q[RadBits-1 -: 2]};
  assign trial     = {1'b0, root_q, 2'b01};
  assign fit       = rem_cat >= trial;
  assign rem_step  = fit ? (rem_cat - trial) : rem_cat;
  assign root_step = {root_q[ROOT_BITS-2:0], fit};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    fin_d  = 1'b0;
    if (load_i) begin
      busy_d = 1'b1;
      cnt_d  = CntBits'(ROOT_BITS - 1);
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      rad_d  = {rad_q[RadBits-3:0], 2'b00};
      rem_d  = rem_step[ROOT_BITS:0];
      root_d = root_step;
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        fin_d  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q      <= cnt_d;
    rad_q      <= rad_d;
    rem_q      <= rem_d;
    root_q     <= root_d;
    fin_root_q <= root_step;
    dist_q     <= fin_root_q;
    margin_q   <= CmpBits'(fin_root_q) >= CmpBits'(need_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      fin_q  <= fin_d;
      done_q <= fin_q;
    end
  end

  assign done_o   = done_q;
  assign root_o   = dist_q;
  assign margin_o = margin_q;

  `PMID_ASSERT_NEVER(a_load_while_busy, load_i && busy_q, "root unit loaded while busy")
  `PMID_ASSERT(a_done_pulse, done_q |=> !done_q, "done held for two cycles")

endmodule

@@ hdl/periodic_min_image_distance.sv @@
// Top level of the minimum image lattice vector length block.
//
// Usage: drive the nine box coordinates and raise start; a transaction is
// taken at a rising edge with start high and busy low. The block walks all
// (2*SEARCH_RANGE+1)^3 coefficient combinations of the box, one per cycle,
// through a register pipeline (combine, magnitude, square, sum, minimum) and
// then a bit-serial square root unit that yields one root bit per cycle.
// The coefficient sequencer sets the box rate; busy drops in the last
// combination cycle, so the next box may enter while the previous one is
// still in flight.
// Results: done_o is high for one cycle with image_distance_o and
// margin_ok_o; the receiver cannot stall and must take it then.
// Configuration: write max_extent and cutoff_radius through cfg_we_i,
// cfg_idx_i and cfg_wdata_i only while no box is in flight.
// Reset: clears both registers and empties the pipeline.
module periodic_min_image_distance #(
  parameter int unsigned COORD_BITS   = 24,
  parameter int unsigned SEARCH_RANGE = 2,
  localparam int unsigned CoefBits = $clog2(SEARCH_RANGE + 1) + 1,
  localparam int unsigned MagBits  = COORD_BITS - 1 + $clog2(3 * SEARCH_RANGE),
  localparam int unsigned DistBits = MagBits + 1,
  localparam int unsigned LenBits  = 2 * DistBits
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [COORD_BITS-1:0]      vec_a_x_i,
  input  logic signed [COORD_BITS-1:0]      vec_a_y_i,
  input  logic signed [COORD_BITS-1:0]      vec_a_z_i,
  input  logic signed [COORD_BITS-1:0]      vec_b_x_i,
  input  logic signed [COORD_BITS-1:0]      vec_b_y_i,
  input  logic signed [COORD_BITS-1:0]      vec_b_z_i,
  input  logic signed [COORD_BITS-1:0]      vec_c_x_i,
  input  logic signed [COORD_BITS-1:0]      vec_c_y_i,
  input  logic signed [COORD_BITS-1:0]      vec_c_z_i,
  input  logic                              cfg_we_i,
  input  logic [pmid_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [pmid_pkg::REG_BITS-1:0]     cfg_wdata_i,
  output logic                              done_o,
  output logic [DistBits-1:0]               image_distance_o,
  output logic                              margin_ok_o
);

  logic [pmid_pkg::REG_BITS-1:0]  max_extent_q, cutoff_radius_q;
  logic [pmid_pkg::NEED_BITS-1:0] need;
  logic signed [COORD_BITS-1:0]   vec [9];
  logic signed [CoefBits-1:0]     coef_a, coef_b, coef_c;
  logic                           accept;
  pmid_pkg::cand_ctl_t            seq_ctl, len_ctl;
  logic [LenBits-1:0]             len, min_len;
  logic                           min_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_extent_q    <= '0;
      cutoff_radius_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pmid_pkg::CFG_MAX_EXTENT:    max_extent_q    <= cfg_wdata_i;
        pmid_pkg::CFG_CUTOFF_RADIUS: cutoff_radius_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign need = pmid_pkg::NEED_BITS'(max_extent_q)
              + pmid_pkg::NEED_BITS'({cutoff_radius_q, 1'b0});

  assign vec[0] = vec_a_x_i;
  assign vec[1] = vec_a_y_i;
  assign vec[2] = vec_a_z_i;
  assign vec[3] = vec_b_x_i;
  assign vec[4] = vec_b_y_i;
  assign vec[5] = vec_b_z_i;
  assign vec[6] = vec_c_x_i;
  assign vec[7] = vec_c_y_i;
  assign vec[8] = vec_c_z_i;

  pmid_seq #(
    .SEARCH_RANGE(SEARCH_RANGE)
  ) u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .accept_o(accept),
    .coef_a_o(coef_a),
    .coef_b_o(coef_b),
    .coef_c_o(coef_c),
    .ctl_o   (seq_ctl)
  );

  pmid_len #(
    .COORD_BITS  (COORD_BITS),
    .SEARCH_RANGE(SEARCH_RANGE)
  ) u_len (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (accept),
    .vec_i   (vec),
    .coef_a_i(coef_a),
    .coef_b_i(coef_b),
    .coef_c_i(coef_c),
    .ctl_i   (seq_ctl),
    .len_o   (len),
    .ctl_o   (len_ctl)
  );

  pmid_min #(
    .LEN_BITS(LenBits)
  ) u_min (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .len_i (len),
    .ctl_i (len_ctl),
    .load_o(min_load),
    .min_o (min_len)
  );

  pmid_sqrt #(
    .ROOT_BITS(DistBits)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (min_load),
    .rad_i   (min_len),
    .need_i  (need),
    .done_o  (done_o),
    .root_o  (image_distance_o),
    .margin_o(margin_ok_o)
  );

endmodule
